// ===== rtl/core/cgp_pkg.sv =====
// Package for the Clifford geometric product block: sizes, register and class codes,
// blade class filter, reorder sign and Q16.16 rounding/saturation helpers.
// No dependencies.
`default_nettype none
package cgp_pkg;

   localparam int DIM        = 4;
   localparam int BLADES     = 1 << DIM;
   localparam int COMP_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int ACC_W      = 64;
   localparam int Q_W        = ACC_W - FRAC_BITS + 1;
   localparam int CFG_W      = 3;
   localparam int REQ_DATA_W = ((DIM + 2 * COMP_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((DIM + COMP_WIDTH + 7) / 8) * 8;
   localparam int ADDR_W     = 4;

   // register indexes
   localparam logic [1:0] REG_NEG_AXIS     = 2'd0;
   localparam logic [1:0] REG_FIRST_CLASS  = 2'd1;
   localparam logic [1:0] REG_SECOND_CLASS = 2'd2;
   localparam logic [1:0] REG_RESULT_CLASS = 2'd3;

   // class codes
   localparam logic [CFG_W-1:0] CLS_ALL      = 3'd0;
   localparam logic [CFG_W-1:0] CLS_EVEN     = 3'd1;
   localparam logic [CFG_W-1:0] CLS_ODD      = 3'd2;
   localparam logic [CFG_W-1:0] CLS_SCALAR   = 3'd3;
   localparam logic [CFG_W-1:0] CLS_ROTATION = 3'd4;
   localparam logic [CFG_W-1:0] CLS_GRADE1   = 3'd5;
   localparam logic [CFG_W-1:0] CLS_POINCARE = 3'd6;

   localparam logic [DIM-1:0] TOP_AXIS = DIM'(1 << (DIM - 1));

   typedef struct packed {
      logic clear;
      logic valid;
      logic neg;
   } mac_ctrl_type;

   function automatic logic class_pass(input logic [CFG_W-1:0] cls, input logic [DIM-1:0] b);
      logic [DIM-1:0] t;
      logic           par;
      logic           one;
      logic           one_t;
      t     = b ^ TOP_AXIS;
      par   = ^b;
      one   = $onehot(b);
      one_t = $onehot(t);
      case (cls)
         CLS_EVEN:     class_pass = !par;
         CLS_ODD:      class_pass = par;
         CLS_SCALAR:   class_pass = (b == '0);
         CLS_ROTATION: class_pass = !par && (b < TOP_AXIS);
         CLS_GRADE1:   class_pass = one;
         CLS_POINCARE: class_pass = one_t;
         default:      class_pass = 1'b1;
      endcase
   endfunction

   function automatic logic sign_negative(input logic [DIM-1:0] a, input logic [DIM-1:0] b,
                                          input logic [CFG_W-1:0] neg_axis);
      logic [DIM-1:0] m;
      logic           par;
      par = 1'b0;
      for (int k = 0; k < DIM; k++) begin
         m = DIM'((1 << k) - 1);
         if (b[k]) begin
            par = par ^ (^(a & m));
            if ((neg_axis == CFG_W'(k)) && a[k]) par = ~par;
         end
      end
      sign_negative = par;
   endfunction

   function automatic logic signed [COMP_WIDTH-1:0] finish_round(input logic signed [ACC_W-1:0] acc);
      logic signed [Q_W-1:0] q;
      logic signed [Q_W-1:0] hi;
      logic signed [Q_W-1:0] lo;
      hi = $signed({{(Q_W - COMP_WIDTH + 1){1'b0}}, {(COMP_WIDTH - 1){1'b1}}});
      lo = $signed({{(Q_W - COMP_WIDTH + 1){1'b1}}, {(COMP_WIDTH - 1){1'b0}}});
      q  = $signed({acc[ACC_W-1], acc[ACC_W-1:FRAC_BITS]})
         + $signed({{(Q_W - 1){1'b0}}, acc[FRAC_BITS-1]});
      if (q > hi)      finish_round = hi[COMP_WIDTH-1:0];
      else if (q < lo) finish_round = lo[COMP_WIDTH-1:0];
      else             finish_round = q[COMP_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/clifford_geometric_product.sv =====
// Clifford geometric product, top level: CSR port, operand stores, term sequencer.
// Depends on cgp_pkg and cgp_mac.
// Sequencing: request items are taken only while idle; after the final item each of the 16
// product blades is built from 16 term slots through the one shared MAC, then drained and
// emitted, and the result side can stall the emit before the next blade starts.
// Reset: synchronous, clears config to defaults, sequencer to idle, accumulator to zero.
`default_nettype none
module clifford_geometric_product (
   input  wire                                clock,
   input  wire                                reset,
   // req_tdata: blade_index[3:0], first_value[35:4], second_value[67:36], zero pad
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire [cgp_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire                                req_tlast,
   // rsp_tdata: out_index[3:0], out_value[35:4], zero pad
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [cgp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire [cgp_pkg::ADDR_W-1:0]          csr_paddr,
   input  wire [31:0]                         csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import cgp_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_RUN   = 4'b0010,
      S_DRAIN = 4'b0100,
      S_EMIT  = 4'b1000
   } state_type;

   state_type                      state_ff, state_in;
   logic [CFG_W-1:0]               neg_axis_ff, first_cls_ff, second_cls_ff, result_cls_ff;
   logic signed [COMP_WIDTH-1:0]   first_mem [BLADES];
   logic signed [COMP_WIDTH-1:0]   second_mem [BLADES];
   logic signed [COMP_WIDTH-1:0]   a_rd_ff, b_rd_ff;
   logic                           t1_valid_ff, t1_neg_ff;
   logic [DIM-1:0]                 k_ff, k_in, i_ff, i_in, j_idx;
   logic signed [COMP_WIDTH-1:0]   out_value_ff;
   logic                           issue, term_ok, req_fire, csr_wr;
   mac_ctrl_type                   ctrl;
   logic signed [ACC_W-1:0]        acc;
   logic                           mac_busy;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_axis_ff   <= CFG_W'(DIM);
         first_cls_ff  <= CLS_ALL;
         second_cls_ff <= CLS_ALL;
         result_cls_ff <= CLS_ALL;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_NEG_AXIS:     neg_axis_ff   <= csr_pwdata[CFG_W-1:0];
            REG_FIRST_CLASS:  first_cls_ff  <= csr_pwdata[CFG_W-1:0];
            REG_SECOND_CLASS: second_cls_ff <= csr_pwdata[CFG_W-1:0];
            REG_RESULT_CLASS: result_cls_ff <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_NEG_AXIS:     csr_prdata = {29'b0, neg_axis_ff};
         REG_FIRST_CLASS:  csr_prdata = {29'b0, first_cls_ff};
         REG_SECOND_CLASS: csr_prdata = {29'b0, second_cls_ff};
         REG_RESULT_CLASS: csr_prdata = {29'b0, result_cls_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign issue      = (state_ff == S_RUN);
   assign j_idx      = i_ff ^ k_ff;
   assign term_ok    = class_pass(result_cls_ff, k_ff) && class_pass(first_cls_ff, i_ff)
                       && class_pass(second_cls_ff, j_idx);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         first_mem[req_tdata[DIM-1:0]]  <= req_tdata[DIM +: COMP_WIDTH];
         second_mem[req_tdata[DIM-1:0]] <= req_tdata[DIM + COMP_WIDTH +: COMP_WIDTH];
      end
      a_rd_ff   <= first_mem[i_ff];
      b_rd_ff   <= second_mem[j_idx];
      t1_neg_ff <= sign_negative(i_ff, j_idx, neg_axis_ff);
      if (reset) t1_valid_ff <= 1'b0;
      else       t1_valid_ff <= issue & term_ok;
   end

   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      i_in       = i_ff;
      ctrl.clear = 1'b0;
      ctrl.valid = t1_valid_ff;
      ctrl.neg   = t1_neg_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_tlast) begin
               state_in   = S_RUN;
               k_in       = '0;
               i_in       = '0;
               ctrl.clear = 1'b1;
            end
         end
         S_RUN: begin
            i_in = i_ff + 1'b1;
            if (i_ff == DIM'(BLADES - 1)) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (!t1_valid_ff && !mac_busy) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_tready) begin
               if (k_ff == DIM'(BLADES - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  state_in   = S_RUN;
                  k_in       = k_ff + 1'b1;
                  i_in       = '0;
                  ctrl.clear = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
         i_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         i_ff     <= i_in;
      end
      if (state_ff == S_DRAIN) out_value_ff <= finish_round(acc);
   end

   cgp_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .a_val (a_rd_ff),
      .b_val (b_rd_ff),
      .acc   (acc),
      .busy  (mac_busy)
   );

   assign rsp_tvalid = (state_ff == S_EMIT);
   assign rsp_tdata  = {{(RSP_DATA_W - DIM - COMP_WIDTH){1'b0}}, out_value_ff, k_ff};
   assign rsp_tlast  = (k_ff == DIM'(BLADES - 1));
endmodule
`default_nettype wire

// ===== rtl/core/cgp_mac.sv =====
// Shared multiply-accumulate unit: registered signed product, then saturating
// 64-bit accumulate with optional negation. Depends on cgp_pkg.
`default_nettype none
module cgp_mac (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire cgp_pkg::mac_ctrl_type            ctrl,
   input  wire logic signed [cgp_pkg::COMP_WIDTH-1:0] a_val,
   input  wire logic signed [cgp_pkg::COMP_WIDTH-1:0] b_val,
   output logic signed [cgp_pkg::ACC_W-1:0]      acc,
   output logic                                  busy
);
   import cgp_pkg::*;

   logic signed [ACC_W-1:0] prod_full;
   logic signed [ACC_W-1:0] prod_ff;
   logic                    neg_ff;
   logic                    pv_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W-1:0] term;
   logic        [ACC_W:0]   sum;

   assign prod_full = a_val * b_val;

   always_comb begin
      term = neg_ff ? -prod_ff : prod_ff;
      sum  = {acc_ff[ACC_W-1], acc_ff} + {term[ACC_W-1], term};
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         acc_in = sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
      end else begin
         acc_in = sum[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_full;
      neg_ff  <= ctrl.neg;
      if (reset) begin
         pv_ff  <= 1'b0;
         acc_ff <= '0;
      end else begin
         pv_ff <= ctrl.valid;
         if (ctrl.clear)  acc_ff <= '0;
         else if (pv_ff)  acc_ff <= acc_in;
      end
   end

   assign acc  = acc_ff;
   assign busy = pv_ff;
endmodule
`default_nettype wire
